### sv/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types, codes and keyword tables of the coefficient file parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int COEF_BITS          = 16;  // coefficient width
  localparam int SHOW_BITS          = 16;  // width of the reported count
  localparam int HDR_BITS           = 16;  // saturating header number
  localparam int COUNT_BITS_DEFAULT = 16;

  // line phases
  localparam logic [2:0] PH_START     = 3'd0;
  localparam logic [2:0] PH_NAME      = 3'd1;
  localparam logic [2:0] PH_NAME_TAIL = 3'd2;
  localparam logic [2:0] PH_HVALUE    = 3'd3;
  localparam logic [2:0] PH_SKIP      = 3'd4;
  localparam logic [2:0] PH_DLEAD     = 3'd5;
  localparam logic [2:0] PH_DATA      = 3'd6;

  localparam logic [1:0] RADIX_NONE = 2'd0;
  localparam logic [1:0] RADIX_BIN  = 2'd1;
  localparam logic [1:0] RADIX_DEC  = 2'd2;
  localparam logic [1:0] RADIX_HEX  = 2'd3;

  // result kinds; the error kinds double as the latched error code
  localparam logic [1:0] KIND_COEF   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_FORMAT = 2'd2;
  localparam logic [1:0] KIND_WIDTH  = 2'd3;
  localparam logic [1:0] ERR_NONE    = 2'd0;

  // keyword indexes (bit positions in the candidate mask)
  localparam logic [1:0] KW_RADIX = 2'd0;
  localparam logic [1:0] KW_WIDTH = 2'd1;
  localparam logic [1:0] KW_DATA  = 2'd2;

  localparam logic [255:0] KW_RADIX_TXT = 256'("radix");
  localparam logic [255:0] KW_WIDTH_TXT = 256'({"coefficient", "_width"});
  localparam logic [255:0] KW_DATA_TXT  = 256'("coefdata");

  typedef struct packed {
    logic       eof;
    logic [7:0] lc;        // character, lowercased
    logic       is_nl;
    logic       is_semi;
    logic       is_space;
    logic       is_tab;
    logic       is_comma;
    logic       is_eq;
    logic       is_dot;
    logic       is_minus;
    logic       is_e;      // lowercase e only
    logic       is_dec;
    logic       is_bin;
    logic       is_hex;
    logic [3:0] digit;
    logic       is_r;
    logic       is_c;
  } chr_cls_t;

  typedef struct packed {
    logic [1:0]           radix;
    logic                 data_started;
    logic [2:0]           phase;
    logic [4:0]           kw_pos;
    logic [2:0]           kw_cand;
    logic [COEF_BITS-1:0] acc;
    logic [HDR_BITS-1:0]  hdr;
    logic                 neg;
    logic                 dot;
    logic                 bad;
    logic                 expo;
    logic                 tok_pend;
    logic [1:0]           err;
  } prs_state_t;

  localparam prs_state_t PRS_RESET = '{
    radix: RADIX_NONE, data_started: 1'b0, phase: PH_START, kw_pos: 5'd0,
    kw_cand: 3'b111, acc: '0, hdr: '0, neg: 1'b0, dot: 1'b0, bad: 1'b0,
    expo: 1'b0, tok_pend: 1'b0, err: ERR_NONE};

  typedef struct packed {
    logic [1:0]           kind;
    logic [COEF_BITS-1:0] value;
    logic [SHOW_BITS-1:0] count;
    logic                 last;
  } res_t;

  function automatic logic [4:0] kw_len(input logic [1:0] k);
    logic [4:0] n;
    case (k)
      KW_RADIX: n = 5'd5;
      KW_WIDTH: n = 5'd17;
      KW_DATA:  n = 5'd8;
      default:  n = 5'd0;
    endcase
    return n;
  endfunction

  // character at position pos of keyword k (pos below its length)
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [4:0] pos);
    logic [255:0] txt;
    logic [4:0]   idx;
    case (k)
      KW_RADIX: txt = KW_RADIX_TXT;
      KW_WIDTH: txt = KW_WIDTH_TXT;
      KW_DATA:  txt = KW_DATA_TXT;
      default:  txt = '0;
    endcase
    idx = kw_len(k) - 5'd1 - pos;
    return txt[{idx, 3'b000} +: 8];
  endfunction

endpackage

### sv/cfp_front.sv
// ----------------------------------------------------------------------------
// cfp_front
// Accepts characters, decodes their class and queues them for the parser.
// ----------------------------------------------------------------------------
module cfp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // char_code
  input  logic              s_axis_tlast,   // end_of_file
  output logic              out_valid,
  output cfp_pkg::chr_cls_t out_item,
  input  logic              out_take
);

  cfp_pkg::chr_cls_t cls;
  cfp_pkg::chr_cls_t entry [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              push;
  logic [7:0]        c;
  logic              upper;
  logic              hex_letter;

  always_comb begin
    c          = s_axis_tdata;
    upper      = (c >= 8'h41) && (c <= 8'h5a);
    hex_letter = ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
    cls.eof      = s_axis_tlast;
    cls.lc       = upper ? (c + 8'd32) : c;
    cls.is_nl    = (c == 8'h0a);
    cls.is_semi  = (c == 8'h3b);
    cls.is_space = (c == 8'h20);
    cls.is_tab   = (c == 8'h09);
    cls.is_comma = (c == 8'h2c);
    cls.is_eq    = (c == 8'h3d);
    cls.is_dot   = (c == 8'h2e);
    cls.is_minus = (c == 8'h2d);
    cls.is_e     = (c == 8'h65);
    cls.is_dec   = (c >= 8'h30) && (c <= 8'h39);
    cls.is_bin   = (c == 8'h30) || (c == 8'h31);
    cls.is_hex   = cls.is_dec || hex_letter;
    // digits carry their value in the low nibble, hex letters the low nibble plus nine
    cls.digit    = hex_letter ? (c[3:0] + 4'd9) : c[3:0];
    cls.is_r     = (cls.lc == 8'h72);
    cls.is_c     = (cls.lc == 8'h63);
  end

  assign s_axis_tready = (fill != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign out_valid     = (fill != 2'd0);
  assign out_item      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (out_take) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, out_take};
    end
  end

endmodule

### sv/cfp_parse.sv
// ----------------------------------------------------------------------------
// cfp_parse
// Line and token state machine: one classified character per cycle while
// the result queue has room, up to two results per character.
// ----------------------------------------------------------------------------
module cfp_parse #(
  parameter int COUNT_BITS = cfp_pkg::COUNT_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  cfp_pkg::chr_cls_t in_item,
  output logic              in_take,
  input  logic              room,
  output logic [1:0]        push_n,
  output cfp_pkg::res_t     res0,
  output cfp_pkg::res_t     res1
);

  localparam int ShowBits = cfp_pkg::SHOW_BITS;
  localparam int CoefBits = cfp_pkg::COEF_BITS;
  localparam int WideBits = (COUNT_BITS > ShowBits) ? COUNT_BITS : ShowBits;

  cfp_pkg::prs_state_t   prs;
  cfp_pkg::prs_state_t   prs_next;
  logic [COUNT_BITS-1:0] emitted_count;
  logic [COUNT_BITS-1:0] emitted_count_next;

  cfp_pkg::prs_state_t   el;
  logic [COUNT_BITS-1:0] el_cnt;
  logic                  el_got;
  logic [CoefBits-1:0]   el_val;
  logic                  hv_ok;
  cfp_pkg::prs_state_t   dsrc;
  cfp_pkg::prs_state_t   dfed;
  logic [COUNT_BITS-1:0] comma_cnt;
  logic [2:0]            kw_hit;
  logic [2:0]            cand_kept;
  logic                  do_data;
  logic                  do_fin;
  cfp_pkg::chr_cls_t     it;

  function automatic cfp_pkg::prs_state_t clear_tok(input cfp_pkg::prs_state_t s);
    cfp_pkg::prs_state_t r;
    r          = s;
    r.acc      = '0;
    r.hdr      = '0;
    r.neg      = 1'b0;
    r.dot      = 1'b0;
    r.bad      = 1'b0;
    r.expo     = 1'b0;
    r.tok_pend = 1'b0;
    return r;
  endfunction

  function automatic logic [CoefBits-1:0] tok_val(input cfp_pkg::prs_state_t s);
    logic [CoefBits-1:0] v;
    v = s.acc;
    if (s.bad) begin
      v = '0;
    end else if (s.radix == cfp_pkg::RADIX_DEC && s.neg) begin
      v = -s.acc;
    end
    return v;
  endfunction

  function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] n);
    return (n == '1) ? n : n + COUNT_BITS'(1);
  endfunction

  function automatic logic [ShowBits-1:0] show_count(input logic [COUNT_BITS-1:0] n);
    logic [WideBits-1:0] w;
    w = WideBits'(n);
    if (w > WideBits'({ShowBits{1'b1}})) begin
      return '1;
    end
    return w[ShowBits-1:0];
  endfunction

  // decimal number: integer part only, '-' anywhere, 'e' ends the value
  function automatic cfp_pkg::prs_state_t dec_feed(input cfp_pkg::prs_state_t s,
                                                   input cfp_pkg::chr_cls_t c,
                                                   input logic to_hdr);
    cfp_pkg::prs_state_t r;
    logic [cfp_pkg::HDR_BITS+3:0] n;
    r = s;
    n = ({4'd0, s.hdr} << 3) + ({4'd0, s.hdr} << 1) + (cfp_pkg::HDR_BITS + 4)'(c.digit);
    if (!(s.bad || s.expo || c.is_space)) begin
      if (c.is_dec) begin
        if (!s.dot) begin
          if (to_hdr) begin
            r.hdr = (n > (cfp_pkg::HDR_BITS + 4)'({cfp_pkg::HDR_BITS{1'b1}})) ? '1
                                                      : n[cfp_pkg::HDR_BITS-1:0];
          end else begin
            r.acc = (s.acc << 3) + (s.acc << 1) + CoefBits'(c.digit);
          end
        end
      end else if (c.is_dot && !s.dot) begin
        r.dot = 1'b1;
      end else if (c.is_minus) begin
        r.neg = 1'b1;
      end else if (c.is_e) begin
        r.expo = 1'b1;
      end else begin
        r.bad = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic cfp_pkg::prs_state_t data_feed(input cfp_pkg::prs_state_t s,
                                                    input cfp_pkg::chr_cls_t c);
    cfp_pkg::prs_state_t r;
    r          = s;
    r.tok_pend = 1'b1;
    if (s.radix == cfp_pkg::RADIX_DEC) begin
      r = dec_feed(r, c, 1'b0);
    end else if (!(s.bad || c.is_space)) begin
      if (s.radix == cfp_pkg::RADIX_HEX) begin
        if (c.is_hex) begin
          r.acc = {s.acc[CoefBits-5:0], c.digit};
        end else begin
          r.bad = 1'b1;
        end
      end else if (c.is_bin) begin
        r.acc = {s.acc[CoefBits-2:0], c.digit[0]};
      end else begin
        r.bad = 1'b1;
      end
    end
    return r;
  endfunction

  assign it      = in_item;
  assign in_take = in_valid && room;

  // outcome of ending the current line, shared by newline, ';' and end of file
  always_comb begin
    el     = prs;
    el_cnt = emitted_count;
    el_got = 1'b0;
    el_val = tok_val(prs);
    hv_ok  = !prs.bad && !prs.neg;
    unique case (prs.phase)
      cfp_pkg::PH_NAME, cfp_pkg::PH_NAME_TAIL: el.err = cfp_pkg::KIND_FORMAT;
      cfp_pkg::PH_HVALUE: begin
        if (prs.kw_cand == 3'b001) begin
          if (hv_ok && prs.hdr == 16'd2) begin
            el.radix = cfp_pkg::RADIX_BIN;
          end else if (hv_ok && prs.hdr == 16'd10) begin
            el.radix = cfp_pkg::RADIX_DEC;
          end else if (hv_ok && prs.hdr == 16'd16) begin
            el.radix = cfp_pkg::RADIX_HEX;
          end else begin
            el.err = cfp_pkg::KIND_FORMAT;
          end
        end else if (!(hv_ok && prs.hdr == 16'd16)) begin
          el.err = cfp_pkg::KIND_WIDTH;
        end
      end
      cfp_pkg::PH_DATA: begin
        if (prs.tok_pend) begin
          el_got = 1'b1;
          el_cnt = cnt_inc(emitted_count);
        end
      end
      default: ;
    endcase
    el       = clear_tok(el);
    el.phase = cfp_pkg::PH_START;
  end

  // keyword match bookkeeping
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      kw_hit[k]    = prs.kw_cand[k] && (prs.kw_pos == cfp_pkg::kw_len(2'(k)));
      cand_kept[k] = prs.kw_cand[k] && (prs.kw_pos < cfp_pkg::kw_len(2'(k))) &&
                     (it.lc == cfp_pkg::kw_char(2'(k), prs.kw_pos));
    end
  end

  // token source: a data line's first character starts from a cleared token
  always_comb begin
    dsrc       = clear_tok(prs);
    dsrc.phase = cfp_pkg::PH_DATA;
    if (prs.phase == cfp_pkg::PH_DATA) begin
      dsrc = prs;
    end
    dfed      = data_feed(dsrc, it);
    comma_cnt = cnt_inc(emitted_count);
  end

  always_comb begin
    prs_next           = prs;
    emitted_count_next = emitted_count;
    push_n             = 2'd0;
    res0               = '0;
    res1               = '0;
    do_data            = 1'b0;
    do_fin             = 1'b0;
    if (in_take) begin
      if (it.eof) begin
        if (prs.err != cfp_pkg::ERR_NONE) begin
          res0   = '{kind: prs.err, value: '0, count: show_count(emitted_count), last: 1'b1};
          push_n = 2'd1;
        end else if (el.err != cfp_pkg::ERR_NONE) begin
          res0   = '{kind: el.err, value: '0, count: show_count(el_cnt), last: 1'b1};
          push_n = 2'd1;
        end else if (el_got) begin
          res0   = '{kind: cfp_pkg::KIND_COEF, value: el_val, count: show_count(el_cnt),
                     last: 1'b0};
          res1   = '{kind: cfp_pkg::KIND_END, value: '0, count: show_count(el_cnt),
                     last: 1'b1};
          push_n = 2'd2;
        end else begin
          res0   = '{kind: cfp_pkg::KIND_END, value: '0, count: show_count(el_cnt),
                     last: 1'b1};
          push_n = 2'd1;
        end
        prs_next           = cfp_pkg::PRS_RESET;
        emitted_count_next = '0;
      end else if (prs.err == cfp_pkg::ERR_NONE) begin
        unique case (prs.phase)
          cfp_pkg::PH_START: begin
            if (it.is_space || it.is_tab || it.is_nl) begin
              prs_next = prs;
            end else if (it.is_semi) begin
              prs_next.phase = cfp_pkg::PH_SKIP;
            end else if (prs.data_started) begin
              do_data = 1'b1;
            end else begin
              prs_next.kw_pos = 5'd1;
              if (it.is_r) begin
                prs_next.kw_cand = 3'b001;
                prs_next.phase   = cfp_pkg::PH_NAME;
              end else if (it.is_c) begin
                prs_next.kw_cand = 3'b110;
                prs_next.phase   = cfp_pkg::PH_NAME;
              end else begin
                prs_next.phase = cfp_pkg::PH_SKIP;
              end
            end
          end
          cfp_pkg::PH_NAME, cfp_pkg::PH_NAME_TAIL: begin
            if (it.is_nl || it.is_semi) begin
              do_fin = 1'b1;
            end else if (it.is_eq) begin
              prs_next = clear_tok(prs);
              if (kw_hit[0]) begin
                prs_next.kw_cand = 3'b001;
                prs_next.phase   = cfp_pkg::PH_HVALUE;
              end else if (kw_hit[1]) begin
                prs_next.kw_cand = 3'b010;
                prs_next.phase   = cfp_pkg::PH_HVALUE;
              end else if (kw_hit[2]) begin
                prs_next.data_started = 1'b1;
                prs_next.phase        = cfp_pkg::PH_DLEAD;
              end else begin
                prs_next.phase = cfp_pkg::PH_SKIP;
              end
            end else if (it.is_space) begin
              prs_next.phase = cfp_pkg::PH_NAME_TAIL;
            end else if (prs.phase == cfp_pkg::PH_NAME_TAIL) begin
              // text after a blank inside the name: no keyword can match
              prs_next.kw_cand = 3'b000;
              prs_next.phase   = cfp_pkg::PH_NAME;
            end else begin
              prs_next.kw_cand = cand_kept;
              prs_next.kw_pos  = (prs.kw_pos == 5'd31) ? prs.kw_pos : prs.kw_pos + 5'd1;
            end
          end
          cfp_pkg::PH_HVALUE: begin
            if (it.is_nl || it.is_semi) begin
              do_fin = 1'b1;
            end else begin
              prs_next = dec_feed(prs, it, 1'b1);
            end
          end
          cfp_pkg::PH_DLEAD: begin
            if (it.is_space) begin
              prs_next = prs;
            end else if (it.is_nl) begin
              prs_next.phase = cfp_pkg::PH_START;
            end else if (it.is_semi) begin
              prs_next.phase = cfp_pkg::PH_SKIP;
            end else begin
              do_data = 1'b1;
            end
          end
          cfp_pkg::PH_DATA: do_data = 1'b1;
          default: begin
            if (it.is_nl) begin
              prs_next.phase = cfp_pkg::PH_START;
            end
          end
        endcase

        if (do_data) begin
          if (it.is_nl || it.is_semi) begin
            do_fin = 1'b1;
          end else if (it.is_comma) begin
            prs_next           = clear_tok(dsrc);
            emitted_count_next = comma_cnt;
            res0   = '{kind: cfp_pkg::KIND_COEF, value: tok_val(dsrc),
                       count: show_count(comma_cnt), last: 1'b1};
            push_n = 2'd1;
          end else begin
            prs_next = dfed;
          end
        end

        if (do_fin) begin
          prs_next           = el;
          emitted_count_next = el_cnt;
          if (it.is_semi) begin
            prs_next.phase = cfp_pkg::PH_SKIP;
          end
          if (el.err != cfp_pkg::ERR_NONE) begin
            res0   = '{kind: el.err, value: '0, count: show_count(el_cnt), last: 1'b1};
            push_n = 2'd1;
          end else if (el_got) begin
            res0   = '{kind: cfp_pkg::KIND_COEF, value: el_val, count: show_count(el_cnt),
                       last: 1'b1};
            push_n = 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prs           <= cfp_pkg::PRS_RESET;
      emitted_count <= '0;
    end else begin
      prs           <= prs_next;
      emitted_count <= emitted_count_next;
    end
  end

`ifndef SYNTH
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (prs.err != cfp_pkg::ERR_NONE && !(in_take && it.eof)) |=> (prs.err == $past(prs.err)))
    else $error("latched error changed before end of file");

  a_count_no_wrap: assert property (@(posedge clk) disable iff (rst)
    !(in_take && it.eof) |=> (emitted_count >= $past(emitted_count)))
    else $error("coefficient count went backwards");

  a_silent_after_err: assert property (@(posedge clk) disable iff (rst)
    (in_take && !it.eof && prs.err != cfp_pkg::ERR_NONE) |-> (push_n == 2'd0))
    else $error("result produced while an error is latched");

  a_pair_only_at_eof: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2) |-> (in_take && it.eof && res1.kind == cfp_pkg::KIND_END))
    else $error("two results outside end of file");
`endif

endmodule

### sv/cfp_result_q.sv
// ----------------------------------------------------------------------------
// cfp_result_q
// Four-entry result queue, up to two writes per cycle, drives the output stream.
// ----------------------------------------------------------------------------
module cfp_result_q (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_n,
  input  cfp_pkg::res_t res0,
  input  cfp_pkg::res_t res1,
  output logic          room,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   m_axis_tdata,   // coef_value, coef_count
  output logic [1:0]    m_axis_tuser,   // kind
  output logic          m_axis_tlast    // last
);

  cfp_pkg::res_t entry [4];
  logic [1:0]    wr_ptr;
  logic [1:0]    rd_ptr;
  logic [2:0]    fill;
  logic          pop;
  cfp_pkg::res_t head;

  assign room          = (fill <= 3'd2);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign head          = entry[rd_ptr];
  assign m_axis_tvalid = (fill != 3'd0);
  assign m_axis_tdata  = {head.count, head.value};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entry[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      entry[wr_ptr + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      fill <= fill + {1'b0, push_n} - {2'b00, pop};
    end
  end

endmodule

### sv/coe_coefficient_file_parser.sv
// ----------------------------------------------------------------------------
// coe_coefficient_file_parser
// Parses a coefficient text file streamed one character per transaction.
// ----------------------------------------------------------------------------
// Input stream: one ASCII character per transaction in s_axis_tdata; a
// transaction with s_axis_tlast high marks end of file (its data is ignored),
// flushes the last token and re-arms the parser for the next file.
// Output stream: results with the kind in m_axis_tuser (coefficient, end with
// count, format error, width error), coefficient and running count in
// m_axis_tdata, and m_axis_tlast on the final result of each character.
// Throughput: one character per cycle. The parser core takes one queued
// character per cycle while the four-entry result queue has two free slots.
// An accepted character passes the input queue register and then the result
// queue register before its result is offered. End of file with a pending
// token yields two results.
// Reset: rst clears both queues and returns the parser to its start state
// (no radix, header section, count zero). When the receiver stalls, results
// collect in the result queue until fewer than two slots are free, then
// characters collect in the two-entry input queue, and s_axis_tready drops.
// ----------------------------------------------------------------------------
module coe_coefficient_file_parser #(
  parameter int COUNT_BITS = cfp_pkg::COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  input  logic        s_axis_tlast,   // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // coef_value [15:0], coef_count [31:16]
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last
);

  logic              item_valid;
  cfp_pkg::chr_cls_t item;
  logic              item_take;
  logic              room;
  logic [1:0]        push_n;
  cfp_pkg::res_t     res0;
  cfp_pkg::res_t     res1;

  cfp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .out_valid     (item_valid),
    .out_item      (item),
    .out_take      (item_take)
  );

  cfp_parse #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_valid),
    .in_item  (item),
    .in_take  (item_take),
    .room     (room),
    .push_n   (push_n),
    .res0     (res0),
    .res1     (res1)
  );

  cfp_result_q u_result_q (
    .clk           (clk),
    .rst           (rst),
    .push_n        (push_n),
    .res0          (res0),
    .res1          (res1),
    .room          (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
